/* rtl/core/vpe_pkg.sv */
// vpe_pkg: shared widths, codes and types for the vector projection unit
// no dependencies; imported by every module under rtl/core

package vpe_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int VEC_W       = 24;

  // edge differences and the cross product / line vector
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int VW     = 2 * DIFF_W + 1;

  // limb split for the wide products
  localparam int LIMB_W = 26;
  localparam int NLV    = (VW + LIMB_W - 1) / LIMB_W;
  localparam int VPAD_W = NLV * LIMB_W;
  localparam int PP_W   = 2 * LIMB_W;
  localparam int GP_W   = LIMB_W + VEC_W;

  localparam int SQ_W   = 2 * VW + 2;
  localparam int VG_W   = VW + VEC_W;
  localparam int DG_W   = VG_W + 3;
  localparam int NLD    = (DG_W + LIMB_W - 1) / LIMB_W;
  localparam int DPAD_W = NLD * LIMB_W;
  localparam int ROW_W  = LIMB_W + DPAD_W;
  localparam int PROD_W = VW + DG_W;
  localparam int NUM_W  = PROD_W + 2;

  // quotient and final result widths
  localparam int Q_W   = VEC_W + 2;
  localparam int RES_W = Q_W + 2;

  localparam int FRONT_STAGES = 11;
  localparam int PIPE_DEPTH   = FRONT_STAGES + Q_W + 1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_SURF = 2'd2;

  localparam logic [1:0] REG_GRAV_X = 2'd0;
  localparam logic [1:0] REG_GRAV_Y = 2'd1;
  localparam logic [1:0] REG_GRAV_Z = 2'd2;

  localparam logic signed [VEC_W-1:0] GRAV_Z_RESET = VEC_W'(-642908);

  typedef enum logic [1:0] {
    CLS_PASS,
    CLS_LINE,
    CLS_SURF
  } elem_class_t;

  typedef struct packed {
    elem_class_t              cls;
    logic [2:0][DIFF_W-1:0]   a;
    logic [2:0][DIFF_W-1:0]   b;
  } work_item_t;

  typedef struct packed {
    logic [2:0][VEC_W-1:0] proj;
    logic                  degenerate;
    logic                  saturated;
  } result_t;

endpackage

/* rtl/core/vector_projection_onto_element_unit.sv */
// vector_projection_onto_element_unit: top level, register port and channel glue
// depends on vpe_pkg, vpe_front, vpe_queue, vpe_back
//
//   port group    dir   handshake              payload
//   input items   in    in_valid / in_ready    element_kind, node0..2 x/y/z
//   results       out   out_valid / out_ready  proj_x/y/z, degenerate, saturated
//   registers     in    psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// one element per cycle sustained while the output is not stalled; from the queue head to
// out_valid an item passes 11 arithmetic stages, 26 divider stages and 1 output register,
// after being registered in the 4-entry queue.
// rst is synchronous; it empties the queue and pipeline and restores the vector
// registers. a stalled output freezes the back pipeline; the queue keeps taking
// transfers until it is full.

module vector_projection_onto_element_unit import vpe_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    element_kind,
  input  logic signed [COORD_WIDTH-1:0] node0_x,
  input  logic signed [COORD_WIDTH-1:0] node0_y,
  input  logic signed [COORD_WIDTH-1:0] node0_z,
  input  logic signed [COORD_WIDTH-1:0] node1_x,
  input  logic signed [COORD_WIDTH-1:0] node1_y,
  input  logic signed [COORD_WIDTH-1:0] node1_z,
  input  logic signed [COORD_WIDTH-1:0] node2_x,
  input  logic signed [COORD_WIDTH-1:0] node2_y,
  input  logic signed [COORD_WIDTH-1:0] node2_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VEC_W-1:0]       proj_x,
  output logic signed [VEC_W-1:0]       proj_y,
  output logic signed [VEC_W-1:0]       proj_z,
  output logic                          degenerate,
  output logic                          saturated
);

  logic signed [VEC_W-1:0] grav [3];
  logic                    q_full;
  logic                    push;
  work_item_t              wr_item;
  logic                    q_valid;
  logic                    q_pop;
  work_item_t              q_item;
  result_t                 result;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grav[0] <= '0;
      grav[1] <= '0;
      grav[2] <= GRAV_Z_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[ADDR_W-1:2])
        REG_GRAV_X: grav[0] <= pwdata[VEC_W-1:0];
        REG_GRAV_Y: grav[1] <= pwdata[VEC_W-1:0];
        REG_GRAV_Z: grav[2] <= pwdata[VEC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_GRAV_X: prdata = DATA_W'(grav[0]);
      REG_GRAV_Y: prdata = DATA_W'(grav[1]);
      REG_GRAV_Z: prdata = DATA_W'(grav[2]);
      default:    prdata = '0;
    endcase
  end

  vpe_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .element_kind (element_kind),
    .node0_x      (node0_x),
    .node0_y      (node0_y),
    .node0_z      (node0_z),
    .node1_x      (node1_x),
    .node1_y      (node1_y),
    .node1_z      (node1_z),
    .node2_x      (node2_x),
    .node2_y      (node2_y),
    .node2_z      (node2_z),
    .q_full       (q_full),
    .push         (push),
    .item         (wr_item)
  );

  vpe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_item  (wr_item),
    .full     (q_full),
    .rd_valid (q_valid),
    .pop      (q_pop),
    .rd_item  (q_item)
  );

  vpe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .grav      (grav),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign proj_x     = result.proj[0];
  assign proj_y     = result.proj[1];
  assign proj_z     = result.proj[2];
  assign degenerate = result.degenerate;
  assign saturated  = result.saturated;

endmodule

/* rtl/core/vpe_front.sv */
// vpe_front: classifies an incoming element and forms its edge vectors
// depends on vpe_pkg; feeds vpe_queue

module vpe_front import vpe_pkg::*; (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    element_kind,
  input  logic signed [COORD_WIDTH-1:0] node0_x,
  input  logic signed [COORD_WIDTH-1:0] node0_y,
  input  logic signed [COORD_WIDTH-1:0] node0_z,
  input  logic signed [COORD_WIDTH-1:0] node1_x,
  input  logic signed [COORD_WIDTH-1:0] node1_y,
  input  logic signed [COORD_WIDTH-1:0] node1_z,
  input  logic signed [COORD_WIDTH-1:0] node2_x,
  input  logic signed [COORD_WIDTH-1:0] node2_y,
  input  logic signed [COORD_WIDTH-1:0] node2_z,
  input  logic                          q_full,
  output logic                          push,
  output work_item_t                    item
);

  logic signed [COORD_WIDTH-1:0] p0 [3];
  logic signed [COORD_WIDTH-1:0] p1 [3];
  logic signed [COORD_WIDTH-1:0] p2 [3];
  elem_class_t cls;

  assign p0[0] = node0_x;
  assign p0[1] = node0_y;
  assign p0[2] = node0_z;
  assign p1[0] = node1_x;
  assign p1[1] = node1_y;
  assign p1[2] = node1_z;
  assign p2[0] = node2_x;
  assign p2[1] = node2_y;
  assign p2[2] = node2_z;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    unique case (element_kind)
      KIND_LINE: cls = CLS_LINE;
      KIND_SURF: cls = CLS_SURF;
      default:   cls = CLS_PASS;
    endcase
  end

  // line: a = node0 - node1; surface: edges from node0
  always_comb begin
    item.cls = cls;
    for (int j = 0; j < 3; j++) begin
      if (cls == CLS_SURF) begin
        item.a[j] = DIFF_W'(p1[j]) - DIFF_W'(p0[j]);
        item.b[j] = DIFF_W'(p2[j]) - DIFF_W'(p0[j]);
      end else begin
        item.a[j] = DIFF_W'(p0[j]) - DIFF_W'(p1[j]);
        item.b[j] = '0;
      end
    end
  end

endmodule

/* rtl/core/vpe_queue.sv */
// vpe_queue: short fifo between the classifying front and the arithmetic back
// depends on vpe_pkg

module vpe_queue import vpe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  work_item_t wr_item,
  output logic       full,
  output logic       rd_valid,
  input  logic       pop,
  output work_item_t rd_item
);

  work_item_t mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_pop;

  assign full     = (count == (QPTR_W + 1)'(QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = mem[rd_ptr];
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/vpe_back.sv */
// vpe_back: projection datapath, products, dot products and pipelined divider
// depends on vpe_pkg; pulls work items from vpe_queue

module vpe_back import vpe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_pop,
  input  work_item_t        q_item,
  input  logic signed [VEC_W-1:0] grav [3],
  output logic              out_valid,
  input  logic              out_ready,
  output result_t           result
);

  typedef struct packed {
    elem_class_t cls;
    logic        degen;
    logic [2:0]  vneg;
    logic        dgneg;
    logic [2:0]  qneg;
  } meta_t;

  logic [PIPE_DEPTH-1:0] vld;
  logic                  adv;

  assign adv       = !vld[PIPE_DEPTH-1] || out_ready;
  assign q_pop     = adv;
  assign out_valid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_DEPTH-2:0], q_valid};
    end
  end

  // magnitude and sign of the configured vector
  logic [VEC_W-1:0] gmag [3];
  logic [2:0]       gneg;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      gneg[j] = grav[j][VEC_W-1];
      gmag[j] = gneg[j] ? (~grav[j] + 1'b1) : grav[j];
    end
  end

  // stage 1: cross product terms
  logic signed [2*DIFF_W-1:0] s1_pr [6];
  logic signed [DIFF_W-1:0]   s1_a  [3];
  meta_t                      s1_m;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pr[0] <= $signed(q_item.a[1]) * $signed(q_item.b[2]);
      s1_pr[1] <= $signed(q_item.a[2]) * $signed(q_item.b[1]);
      s1_pr[2] <= $signed(q_item.a[2]) * $signed(q_item.b[0]);
      s1_pr[3] <= $signed(q_item.a[0]) * $signed(q_item.b[2]);
      s1_pr[4] <= $signed(q_item.a[0]) * $signed(q_item.b[1]);
      s1_pr[5] <= $signed(q_item.a[1]) * $signed(q_item.b[0]);
      for (int j = 0; j < 3; j++) begin
        s1_a[j] <= $signed(q_item.a[j]);
      end
      s1_m <= {q_item.cls, 1'b0, 3'b000, 1'b0, 3'b000};
    end
  end

  // stage 2: direction vector (normal or edge)
  logic signed [VW-1:0] s2_v [3];
  meta_t                s2_m;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        s2_v[j] <= (s1_m.cls == CLS_SURF) ? VW'(s1_pr[2*j]) - VW'(s1_pr[2*j+1])
                                          : VW'(s1_a[j]);
      end
      s2_m <= s1_m;
    end
  end

  // stage 3: sign / magnitude
  logic [VW-1:0] s3_mag [3];
  meta_t         s3_m;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_m <= {s2_m.cls, s2_m.degen,
               s2_v[2][VW-1], s2_v[1][VW-1], s2_v[0][VW-1],
               s2_m.dgneg, s2_m.qneg};
      for (int j = 0; j < 3; j++) begin
        s3_mag[j] <= s2_v[j][VW-1] ? (~s2_v[j] + 1'b1) : s2_v[j];
      end
    end
  end

  // stage 4: limb partial products for |v_j|^2 and |v_j||g_j|
  logic [VPAD_W-1:0] s3_pad [3];
  logic [PP_W-1:0]   s4_sq  [3][NLV][NLV];
  logic [GP_W-1:0]   s4_gp  [3][NLV];
  logic [VW-1:0]     s4_mag [3];
  meta_t             s4_m;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s3_pad[j] = VPAD_W'(s3_mag[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < NLV; i++) begin
          for (int k = 0; k < NLV; k++) begin
            s4_sq[j][i][k] <= s3_pad[j][i*LIMB_W +: LIMB_W] * s3_pad[j][k*LIMB_W +: LIMB_W];
          end
          s4_gp[j][i] <= s3_pad[j][i*LIMB_W +: LIMB_W] * gmag[j];
        end
      end
      s4_mag <= s3_mag;
      s4_m   <= s3_m;
    end
  end

  // stage 5: assemble the squares and |v_j g_j|
  logic [SQ_W-1:0] sq_sum [3];
  logic [VG_W-1:0] vg_sum [3];
  logic [SQ_W-1:0] s5_sq  [3];
  logic [VG_W-1:0] s5_vg  [3];
  logic [VW-1:0]   s5_mag [3];
  meta_t           s5_m;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sq_sum[j] = '0;
      vg_sum[j] = '0;
      for (int i = 0; i < NLV; i++) begin
        for (int k = 0; k < NLV; k++) begin
          sq_sum[j] = sq_sum[j] + (SQ_W'(s4_sq[j][i][k]) << (LIMB_W * (i + k)));
        end
        vg_sum[j] = vg_sum[j] + (VG_W'(s4_gp[j][i]) << (LIMB_W * i));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_sq  <= sq_sum;
      s5_vg  <= vg_sum;
      s5_mag <= s4_mag;
      s5_m   <= s4_m;
    end
  end

  // stage 6: v.v and signed terms of v.g
  logic [SQ_W-1:0]     s6_dotv;
  logic signed [VG_W:0] s6_t [3];
  logic [VW-1:0]       s6_mag [3];
  meta_t               s6_m;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_dotv <= s5_sq[0] + s5_sq[1] + s5_sq[2];
      for (int j = 0; j < 3; j++) begin
        s6_t[j] <= (s5_m.vneg[j] ^ gneg[j]) ? -$signed({1'b0, s5_vg[j]})
                                             : $signed({1'b0, s5_vg[j]});
      end
      s6_mag <= s5_mag;
      s6_m   <= s5_m;
    end
  end

  // stage 7: v.g, zero-length check
  logic signed [DG_W-1:0] s7_dotg;
  logic [SQ_W-1:0]        s7_dotv;
  logic [VW-1:0]          s7_mag [3];
  meta_t                  s7_m;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_dotg <= DG_W'(s6_t[0]) + DG_W'(s6_t[1]) + DG_W'(s6_t[2]);
      s7_dotv <= s6_dotv;
      s7_mag  <= s6_mag;
      s7_m    <= {s6_m.cls, (s6_dotv == '0), s6_m.vneg, s6_m.dgneg, s6_m.qneg};
    end
  end

  // stage 8: |v.g|
  logic [DG_W-1:0] s8_dgmag;
  logic [SQ_W-1:0] s8_dotv;
  logic [VW-1:0]   s8_mag [3];
  meta_t           s8_m;

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_dgmag <= s7_dotg[DG_W-1] ? (~s7_dotg + 1'b1) : s7_dotg;
      s8_dotv  <= s7_dotv;
      s8_mag   <= s7_mag;
      s8_m     <= {s7_m.cls, s7_m.degen, s7_m.vneg, s7_dotg[DG_W-1], s7_m.qneg};
    end
  end

  // stage 9: limb products of |v_j| * |v.g|
  logic [VPAD_W-1:0] s8_vpad [3];
  logic [DPAD_W-1:0] s8_dpad;
  logic [PP_W-1:0]   s9_pp [3][NLV][NLD];
  logic [SQ_W-1:0]   s9_dotv;
  meta_t             s9_m;

  always_comb begin
    s8_dpad = DPAD_W'(s8_dgmag);
    for (int j = 0; j < 3; j++) begin
      s8_vpad[j] = VPAD_W'(s8_mag[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < NLV; i++) begin
          for (int k = 0; k < NLD; k++) begin
            s9_pp[j][i][k] <= s8_vpad[j][i*LIMB_W +: LIMB_W] * s8_dpad[k*LIMB_W +: LIMB_W];
          end
        end
      end
      s9_dotv <= s8_dotv;
      s9_m    <= s8_m;
    end
  end

  // stage 10: one row per limb of |v_j|
  logic [ROW_W-1:0] row_sum [3][NLV];
  logic [ROW_W-1:0] s10_row [3][NLV];
  logic [SQ_W-1:0]  s10_dotv;
  meta_t            s10_m;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < NLV; i++) begin
        row_sum[j][i] = '0;
        for (int k = 0; k < NLD; k++) begin
          row_sum[j][i] = row_sum[j][i] + (ROW_W'(s9_pp[j][i][k]) << (LIMB_W * k));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_row  <= row_sum;
      s10_dotv <= s9_dotv;
      s10_m    <= s9_m;
    end
  end

  // stage 11: rounding numerator 2|p| + d and denominator 2d
  logic [NUM_W-1:0] num_sum [3];
  logic [NUM_W-1:0] s11_num [3];
  logic [NUM_W-1:0] s11_den;
  meta_t            s11_m;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      num_sum[j] = NUM_W'(s10_dotv);
      for (int i = 0; i < NLV; i++) begin
        num_sum[j] = num_sum[j] + (NUM_W'(s10_row[j][i]) << (LIMB_W * i + 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s11_num <= num_sum;
      s11_den <= NUM_W'(s10_dotv) << 1;
      s11_m   <= {s10_m.cls, s10_m.degen, s10_m.vneg, s10_m.dgneg,
                  s10_m.vneg ^ {3{s10_m.dgneg}}};
    end
  end

  // restoring divider, one quotient bit per stage, msb first
  logic [NUM_W-1:0] dv_rem [Q_W][3];
  logic [Q_W-1:0]   dv_q   [Q_W][3];
  logic [NUM_W-1:0] dv_den [Q_W];
  meta_t            dv_m   [Q_W];

  logic [NUM_W-1:0] cur_rem [Q_W][3];
  logic [Q_W-1:0]   cur_q   [Q_W][3];
  logic [NUM_W-1:0] cur_den [Q_W];
  meta_t            cur_m   [Q_W];
  logic [NUM_W-1:0] den_sh  [Q_W];
  logic [2:0]       ge      [Q_W];

  always_comb begin
    for (int t = 0; t < Q_W; t++) begin
      if (t == 0) begin
        cur_rem[t] = s11_num;
        cur_den[t] = s11_den;
        cur_m[t]   = s11_m;
        for (int j = 0; j < 3; j++) begin
          cur_q[t][j] = '0;
        end
      end else begin
        cur_rem[t] = dv_rem[t-1];
        cur_den[t] = dv_den[t-1];
        cur_m[t]   = dv_m[t-1];
        cur_q[t]   = dv_q[t-1];
      end
      den_sh[t] = cur_den[t] << (Q_W - 1 - t);
      for (int j = 0; j < 3; j++) begin
        ge[t][j] = (cur_rem[t][j] >= den_sh[t]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int t = 0; t < Q_W; t++) begin
        for (int j = 0; j < 3; j++) begin
          dv_rem[t][j] <= ge[t][j] ? (cur_rem[t][j] - den_sh[t]) : cur_rem[t][j];
          dv_q[t][j]   <= {cur_q[t][j][Q_W-2:0], ge[t][j]};
        end
        dv_den[t] <= cur_den[t];
        dv_m[t]   <= cur_m[t];
      end
    end
  end

  // output stage: sign, subtract from g for surfaces, saturate; g for pass, zero if degenerate
  meta_t                     fin_m;
  logic signed [Q_W:0]       qv   [3];
  logic signed [RES_W-1:0]   full [3];
  logic [2:0]                ovf;
  logic [VEC_W-1:0]          clip [3];
  result_t                   res_next;

  assign fin_m = dv_m[Q_W-1];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qv[j] = fin_m.qneg[j] ? -$signed({1'b0, dv_q[Q_W-1][j]})
                            : $signed({1'b0, dv_q[Q_W-1][j]});
      full[j] = (fin_m.cls == CLS_SURF) ? RES_W'(grav[j]) - RES_W'(qv[j]) : RES_W'(qv[j]);
      ovf[j] = !((&full[j][RES_W-1:VEC_W-1]) || !(|full[j][RES_W-1:VEC_W-1]));
      if (!ovf[j]) begin
        clip[j] = full[j][VEC_W-1:0];
      end else if (full[j][RES_W-1]) begin
        clip[j] = {1'b1, {(VEC_W-1){1'b0}}};
      end else begin
        clip[j] = {1'b0, {(VEC_W-1){1'b1}}};
      end
    end
    if (fin_m.cls == CLS_PASS) begin
      for (int j = 0; j < 3; j++) begin
        res_next.proj[j] = grav[j];
      end
      res_next.degenerate = 1'b0;
      res_next.saturated  = 1'b0;
    end else if (fin_m.degen) begin
      res_next.proj       = '0;
      res_next.degenerate = 1'b1;
      res_next.saturated  = 1'b0;
    end else begin
      for (int j = 0; j < 3; j++) begin
        res_next.proj[j] = clip[j];
      end
      res_next.degenerate = 1'b0;
      res_next.saturated  = |ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= res_next;
    end
  end

endmodule

/* dv/tb.sv */
// tb: self-checking testbench for vector_projection_onto_element_unit
// depends on vpe_pkg and the rtl under rtl/core; exact wide-integer projection predictor
`timescale 1ns / 1ps

module tb;
  import vpe_pkg::*;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic signed [255:0] OUT_HI = 256'sd8388607;
  localparam logic signed [255:0] OUT_LO = -256'sd8388608;
  localparam logic [VEC_W-1:0] V_MAX = 24'h7fffff;
  localparam logic [VEC_W-1:0] V_MIN = 24'h800000;

  typedef struct packed {
    logic [1:0]                       kind;
    logic [8:0][COORD_WIDTH-1:0]      node;
  } element_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] element_kind = '0;
  logic signed [COORD_WIDTH-1:0] node0_x = '0, node0_y = '0, node0_z = '0;
  logic signed [COORD_WIDTH-1:0] node1_x = '0, node1_y = '0, node1_z = '0;
  logic signed [COORD_WIDTH-1:0] node2_x = '0, node2_y = '0, node2_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [VEC_W-1:0] proj_x, proj_y, proj_z;
  logic degenerate, saturated;

  vector_projection_onto_element_unit dut (.*);

  always #10 clk = ~clk;

  // gravity copy kept in step with register writes
  logic signed [VEC_W-1:0] grav_x = '0, grav_y = '0, grav_z = GRAV_Z_RESET;

  element_t pending_elems[$];
  result_t  expected_proj[$];
  int       errors = 0;
  int       results_seen = 0;
  int       send_gap = 0;
  int       hold_cnt = 0;
  bit       long_hold_done = 0;

  function automatic result_t project_gravity(element_t e);
    logic signed [255:0] pt[9];
    logic signed [255:0] vec[3], ea[3], eb[3], gw[3];
    logic signed [255:0] dot_g, dot_v, num, val;
    logic [255:0] mag, quo;
    result_t r;
    r = '0;
    for (int i = 0; i < 9; i++) pt[i] = 256'($signed(e.node[i]));
    gw[0] = 256'(grav_x);
    gw[1] = 256'(grav_y);
    gw[2] = 256'(grav_z);
    if (e.kind == KIND_LINE || e.kind == KIND_SURF) begin
      if (e.kind == KIND_LINE) begin
        for (int j = 0; j < 3; j++) vec[j] = pt[j] - pt[3+j];
      end else begin
        for (int j = 0; j < 3; j++) begin
          ea[j] = pt[3+j] - pt[j];
          eb[j] = pt[6+j] - pt[j];
        end
        vec[0] = ea[1] * eb[2] - ea[2] * eb[1];
        vec[1] = ea[2] * eb[0] - ea[0] * eb[2];
        vec[2] = ea[0] * eb[1] - ea[1] * eb[0];
      end
      dot_g = 0;
      dot_v = 0;
      for (int j = 0; j < 3; j++) begin
        dot_g += vec[j] * gw[j];
        dot_v += vec[j] * vec[j];
      end
      if (dot_v == 0) begin
        r.degenerate = 1'b1;
      end else begin
        for (int j = 0; j < 3; j++) begin
          num = vec[j] * dot_g;
          mag = (num < 0) ? $unsigned(-num) : $unsigned(num);
          // round half away from zero on the magnitude
          quo = (2 * mag + $unsigned(dot_v)) / (2 * $unsigned(dot_v));
          if (quo > (256'd1 << 62)) quo = 256'd1 << 62;
          val = (num < 0) ? -$signed(quo) : $signed(quo);
          if (e.kind == KIND_SURF) val = gw[j] - val;
          if (val > OUT_HI) begin
            val = OUT_HI;
            r.saturated = 1'b1;
          end else if (val < OUT_LO) begin
            val = OUT_LO;
            r.saturated = 1'b1;
          end
          r.proj[j] = val[VEC_W-1:0];
        end
      end
    end else begin
      r.proj[0] = grav_x;
      r.proj[1] = grav_y;
      r.proj[2] = grav_z;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // input driver
  always @(posedge clk) begin
    element_t e;
    bit fired;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      fired = in_valid && in_ready;
      if (fired) begin
        e.kind = element_kind;
        e.node = {node2_z, node2_y, node2_x, node1_z, node1_y, node1_x,
                  node0_z, node0_y, node0_x};
        expected_proj.push_back(project_gravity(e));
      end
      if (!in_valid || fired) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_elems.size() > 0) begin
          e = pending_elems.pop_front();
          element_kind <= e.kind;
          {node2_z, node2_y, node2_x, node1_z, node1_y, node1_x,
           node0_z, node0_y, node0_x} <= e.node;
          in_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_proj.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer proj=%0d %0d %0d", $time,
                   proj_x, proj_y, proj_z);
        end else begin
          want = expected_proj.pop_front();
          if (proj_x !== want.proj[0] || proj_y !== want.proj[1] ||
              proj_z !== want.proj[2] || degenerate !== want.degenerate ||
              saturated !== want.saturated) begin
            errors++;
            $display("%0t: expected %0d %0d %0d deg=%0b sat=%0b, got %0d %0d %0d deg=%0b sat=%0b",
                     $time, $signed(want.proj[0]), $signed(want.proj[1]),
                     $signed(want.proj[2]), want.degenerate, want.saturated,
                     proj_x, proj_y, proj_z, degenerate, saturated);
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 100) begin
        // long hold-off so the queue fills and in_ready drops
        long_hold_done = 1;
        hold_cnt = 150;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) < 70);
        if ($urandom_range(0, 199) == 0) hold_cnt = $urandom_range(10, 40);
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [VEC_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * idx);
    pwdata <= DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_GRAV_X: grav_x = val;
      REG_GRAV_Y: grav_y = val;
      default:    grav_z = val;
    endcase
  endtask

  task automatic set_gravity(input logic [VEC_W-1:0] gx, gy, gz);
    reg_write(REG_GRAV_X, gx);
    reg_write(REG_GRAV_Y, gy);
    reg_write(REG_GRAV_Z, gz);
  endtask

  // checked between edges so the driver's updates have settled
  task automatic drain();
    @(negedge clk);
    while (pending_elems.size() > 0 || in_valid || expected_proj.size() > 0)
      @(negedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic add_elem(input logic [1:0] kind,
                          input logic signed [COORD_WIDTH-1:0] a0, a1, a2,
                          b0, b1, b2, c0, c1, c2);
    element_t e;
    e.kind = kind;
    e.node = {c2, c1, c0, b2, b1, b0, a2, a1, a0};
    pending_elems.push_back(e);
  endtask

  task automatic add_random(input int count);
    element_t e;
    int shape;
    for (int n = 0; n < count; n++) begin
      e.kind = $urandom_range(0, 99) < 8 ? 2'($urandom_range(0, 3))
                                         : ($urandom_range(0, 1) ? KIND_LINE : KIND_SURF);
      shape = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) begin
        if (shape < 4) e.node[i] = COORD_WIDTH'($urandom);
        else if (shape < 8) e.node[i] = COORD_WIDTH'($signed(12'($urandom)));
        else e.node[i] = COORD_WIDTH'($signed(3'($urandom)));
      end
      // occasional collapsed geometry
      if (shape == 9) begin
        for (int j = 0; j < 3; j++) e.node[3+j] = e.node[j];
      end
      pending_elems.push_back(e);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset gravity: pass-through, simple line and surface, spare kind
    add_elem(KIND_OTHER, 1, 2, 3, 4, 5, 6, 7, 8, 9);
    add_elem(KIND_SPARE, 1, 2, 3, 4, 5, 6, 7, 8, 9);
    add_elem(KIND_LINE, 0, 0, 65536, 0, 0, 0, 0, 0, 0);
    add_elem(KIND_LINE, 65536, 0, 0, 0, 65536, 0, 0, 0, 0);
    add_elem(KIND_SURF, 0, 0, 0, 65536, 0, 0, 0, 65536, 0);
    add_elem(KIND_SURF, 0, 0, 0, 65536, 0, 0, 0, 0, 65536);
    // zero-length edge and collinear surface
    add_elem(KIND_LINE, 5, -7, 9, 5, -7, 9, 0, 0, 0);
    add_elem(KIND_SURF, 0, 0, 0, 1, 1, 1, 2, 2, 2);
    // coordinate extremes
    add_elem(KIND_LINE, V_MAX, V_MAX, V_MAX, V_MIN, V_MIN, V_MIN, 0, 0, 0);
    add_elem(KIND_LINE, V_MIN, V_MAX, V_MIN, V_MAX, V_MIN, V_MAX, 0, 0, 0);
    add_elem(KIND_SURF, V_MIN, V_MIN, V_MIN, V_MAX, V_MIN, V_MIN, V_MIN, V_MAX, V_MAX);
    add_elem(KIND_SURF, V_MAX, V_MIN, V_MAX, V_MIN, V_MAX, V_MAX, V_MAX, V_MAX, V_MIN);
    drain();

    // large gravity so line results clip
    set_gravity(V_MAX, V_MAX, 24'd0);
    add_elem(KIND_LINE, 2, 1, 0, 0, 0, 0, 0, 0, 0);
    add_elem(KIND_LINE, -2, -1, 0, 0, 0, 0, 0, 0, 0);
    add_elem(KIND_SURF, 0, 0, 0, 1, 0, 0, 0, 0, 1);
    add_elem(KIND_OTHER, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_random(200);
    drain();

    set_gravity(V_MIN, V_MIN, V_MIN);
    add_elem(KIND_LINE, 1, 2, 3, 0, 0, 0, 0, 0, 0);
    add_elem(KIND_SURF, 0, 0, 0, 3, 0, 1, 0, 2, 5);
    add_random(200);
    drain();

    set_gravity(V_MAX, V_MIN, V_MAX);
    add_random(200);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      set_gravity(VEC_W'($urandom), VEC_W'($urandom), VEC_W'($urandom));
      add_random(150);
      drain();
    end

    // back to zero then negative-only z
    set_gravity(24'd0, 24'd0, 24'd0);
    add_random(20);
    drain();
    set_gravity(24'd0, 24'd0, GRAV_Z_RESET);
    add_random(10);
    drain();

    if (errors == 0) begin
      $display("vector_projection_onto_element_unit: match");
    end else begin
      $display("vector_projection_onto_element_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("vector_projection_onto_element_unit: mismatch");
    $finish;
  end

endmodule
